// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset masking (disable iff).
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pmi_pkg.sv =====
// ----------------------------------------------------------------------------
// pmi_pkg
// Types, stage indexes and per-stage step functions of the particle integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package pmi_pkg;

  localparam int COORD_BITS = 24;
  localparam int IN_BITS    = 264;
  localparam int OUT_BITS   = 80;

  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS  = 15;

  localparam int ST_IN   = 0;
  localparam int ST_SQ   = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_ISQ0 = 3;
  localparam int ST_SEL  = ST_ISQ0 + SQRT_STEPS;
  localparam int ST_DIV0 = ST_SEL + 1;
  localparam int ST_DIR  = ST_DIV0 + DIV_STEPS;
  localparam int ST_MUL  = ST_DIR + 1;
  localparam int ST_VEL  = ST_MUL + 1;
  localparam int ST_DMUL = ST_VEL + 1;
  localparam int ST_POS  = ST_DMUL + 1;
  localparam int NUM_ST  = ST_POS + 1;

  localparam logic [2:0] ADDR_LIMIT = 3'd0;
  localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] COORD_MIN = -24'sh800000;
  localparam logic [14:0] UNIT_ONE = 15'd16384;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] rs;
    logic signed [23:0] ts;
    logic signed [15:0] sdx;
    logic signed [15:0] sdy;
    logic [15:0]        dt;
    logic [23:0]        life;
    logic               alive;
    logic               negx;
    logic               negy;
    logic [23:0]        ax;
    logic [23:0]        ay;
    logic [47:0]        sqx;
    logic [47:0]        sqy;
    logic [49:0]        nsh;
    logic [25:0]        rem;
    logic [24:0]        root;
    logic               use_seed;
    logic [39:0]        dsh;
    logic [39:0]        remx;
    logic [39:0]        remy;
    logic [14:0]        qx;
    logic [14:0]        qy;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [39:0] m1;
    logic signed [39:0] m2;
    logic signed [39:0] m3;
    logic signed [39:0] m4;
    logic signed [27:0] nvx;
    logic signed [27:0] nvy;
    logic signed [44:0] dpx;
    logic signed [44:0] dpy;
    logic signed [23:0] npx;
    logic signed [23:0] npy;
  } pl_t;

  // one result bit of the square root
  function automatic pl_t sqrt_step(pl_t a);
    pl_t        r;
    logic [27:0] rem2;
    logic [27:0] trial;
    r     = a;
    rem2  = {a.rem, a.nsh[49:48]};
    trial = {1'b0, a.root, 2'b01};
    if (rem2 >= trial) begin
      r.rem  = 26'(rem2 - trial);
      r.root = {a.root[23:0], 1'b1};
    end else begin
      r.rem  = rem2[25:0];
      r.root = {a.root[23:0], 1'b0};
    end
    r.nsh = {a.nsh[47:0], 2'b00};
    return r;
  endfunction

  // one quotient bit for both lanes
  function automatic pl_t div_step(pl_t a);
    pl_t r;
    r = a;
    if (a.remx >= a.dsh) begin
      r.remx = a.remx - a.dsh;
      r.qx   = {a.qx[13:0], 1'b1};
    end else begin
      r.qx   = {a.qx[13:0], 1'b0};
    end
    if (a.remy >= a.dsh) begin
      r.remy = a.remy - a.dsh;
      r.qy   = {a.qy[13:0], 1'b1};
    end else begin
      r.qy   = {a.qy[13:0], 1'b0};
    end
    r.dsh = {1'b0, a.dsh[39:1]};
    return r;
  endfunction

  function automatic logic signed [23:0] sat_coord(logic signed [30:0] v);
    if (v > 31'(COORD_MAX)) return COORD_MAX;
    if (v < 31'(COORD_MIN)) return COORD_MIN;
    return v[23:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/particle_motion_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// particle_motion_integrator_unit
// One Euler step of a particle with radial and tangential orbit velocity.
// ----------------------------------------------------------------------------
// Takes one particle request per clock and returns one result per request,
// in order. The pipe is built around the bit-serial
// pipelines: 25 stages of square root (one root bit each) for the distance to
// the orbit centre and 15 stages of division (one quotient bit each, x and y
// side by side) for the unit radial vector, plus nine stages of offset,
// square, multiply and add. Throughput is one particle per cycle; the whole
// pipeline holds while the output request is not taken, so nothing is lost or
// repeated. Register near_center_limit (byte address 0) selects the seed
// direction when the distance is at or below it; write it only while idle.
`default_nettype none

`include "assert_macros.svh"

module particle_motion_integrator_unit
  import pmi_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // APB configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  // particle requests
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // pos_x, pos_y, center_x, center_y, vel_x, vel_y, seed_dir_x, seed_dir_y,
  // radial_speed, tangential_speed, life_left, time_step
  input  wire logic [IN_BITS-1:0]  s_tdata,
  // results
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // new_pos_x, new_pos_y, new_life_left, alive, zero pad
  output logic [OUT_BITS-1:0]      m_tdata
);

  logic [7:0] near_center_limit;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      near_center_limit <= 8'd0;
    end else if (psel && penable && pwrite && paddr == ADDR_LIMIT) begin
      near_center_limit <= pwdata[7:0];
    end
  end
  assign prdata = (paddr == ADDR_LIMIT) ? {24'd0, near_center_limit} : 32'd0;

  // pipeline storage
  pl_t  p   [NUM_ST];
  pl_t  nx  [NUM_ST];
  logic vld [NUM_ST];
  logic en;

  // whole pipe advances when the output slot is free or being taken
  assign en       = !vld[NUM_ST-1] || m_tready;
  assign s_tready = en;

  always_comb begin
    pl_t in_pl;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [24:0] adx;
    logic signed [24:0] ady;
    logic signed [41:0] svx;
    logic signed [41:0] svy;
    logic signed [45:0] tpx;
    logic signed [45:0] tpy;
    logic [23:0] lf;
    logic [15:0] st;

    // input decode, offsets, life
    in_pl     = p[ST_IN];
    in_pl.px  = s_tdata[23:0];
    in_pl.py  = s_tdata[47:24];
    in_pl.vx  = s_tdata[119:96];
    in_pl.vy  = s_tdata[143:120];
    in_pl.sdx = s_tdata[159:144];
    in_pl.sdy = s_tdata[175:160];
    in_pl.rs  = s_tdata[199:176];
    in_pl.ts  = s_tdata[223:200];
    lf        = s_tdata[247:224];
    st        = s_tdata[263:248];
    in_pl.dt  = st;
    dx        = 25'(in_pl.px) - 25'($signed(s_tdata[71:48]));
    dy        = 25'(in_pl.py) - 25'($signed(s_tdata[95:72]));
    adx       = dx[24] ? -dx : dx;
    ady       = dy[24] ? -dy : dy;
    in_pl.negx  = dx[24];
    in_pl.negy  = dy[24];
    in_pl.ax    = adx[23:0];
    in_pl.ay    = ady[23:0];
    in_pl.life  = (lf > 24'(st)) ? lf - 24'(st) : 24'd0;
    in_pl.alive = (lf > 24'(st));
    nx[ST_IN]   = in_pl;

    // squares
    nx[ST_SQ]     = p[ST_SQ-1];
    nx[ST_SQ].sqx = p[ST_SQ-1].ax * p[ST_SQ-1].ax;
    nx[ST_SQ].sqy = p[ST_SQ-1].ay * p[ST_SQ-1].ay;

    // sum of squares, root init
    nx[ST_SUM]      = p[ST_SUM-1];
    nx[ST_SUM].nsh  = 50'(p[ST_SUM-1].sqx) + 50'(p[ST_SUM-1].sqy);
    nx[ST_SUM].rem  = 26'd0;
    nx[ST_SUM].root = 25'd0;

    for (int k = 0; k < SQRT_STEPS; k++) begin
      nx[ST_ISQ0+k] = sqrt_step(p[ST_ISQ0+k-1]);
    end

    // near-centre test and divider setup
    nx[ST_SEL]          = p[ST_SEL-1];
    nx[ST_SEL].use_seed = (p[ST_SEL-1].root <= 25'(near_center_limit));
    nx[ST_SEL].remx     = {2'b00, p[ST_SEL-1].ax, 14'd0} + 40'(p[ST_SEL-1].root[24:1]);
    nx[ST_SEL].remy     = {2'b00, p[ST_SEL-1].ay, 14'd0} + 40'(p[ST_SEL-1].root[24:1]);
    nx[ST_SEL].dsh      = {1'b0, p[ST_SEL-1].root, 14'd0};
    nx[ST_SEL].qx       = 15'd0;
    nx[ST_SEL].qy       = 15'd0;

    for (int k = 0; k < DIV_STEPS; k++) begin
      nx[ST_DIV0+k] = div_step(p[ST_DIV0+k-1]);
    end

    // direction
    nx[ST_DIR] = p[ST_DIR-1];
    if (p[ST_DIR-1].use_seed) begin
      nx[ST_DIR].rx = p[ST_DIR-1].sdx;
      nx[ST_DIR].ry = p[ST_DIR-1].sdy;
    end else begin
      nx[ST_DIR].rx = p[ST_DIR-1].negx ? -$signed({1'b0, p[ST_DIR-1].qx})
                                       : $signed({1'b0, p[ST_DIR-1].qx});
      nx[ST_DIR].ry = p[ST_DIR-1].negy ? -$signed({1'b0, p[ST_DIR-1].qy})
                                       : $signed({1'b0, p[ST_DIR-1].qy});
    end

    // speed products; tangent is (-ry, rx)
    nx[ST_MUL]    = p[ST_MUL-1];
    nx[ST_MUL].m1 = p[ST_MUL-1].rx * p[ST_MUL-1].rs;
    nx[ST_MUL].m2 = p[ST_MUL-1].ry * p[ST_MUL-1].ts;
    nx[ST_MUL].m3 = p[ST_MUL-1].ry * p[ST_MUL-1].rs;
    nx[ST_MUL].m4 = p[ST_MUL-1].rx * p[ST_MUL-1].ts;

    // velocity, rounded half up
    svx = 42'(p[ST_VEL-1].m1) - 42'(p[ST_VEL-1].m2) + 42'sd8192;
    svy = 42'(p[ST_VEL-1].m3) + 42'(p[ST_VEL-1].m4) + 42'sd8192;
    nx[ST_VEL]     = p[ST_VEL-1];
    nx[ST_VEL].nvx = 28'(p[ST_VEL-1].vx) + 28'(svx >>> 14);
    nx[ST_VEL].nvy = 28'(p[ST_VEL-1].vy) + 28'(svy >>> 14);

    // displacement
    nx[ST_DMUL]     = p[ST_DMUL-1];
    nx[ST_DMUL].dpx = p[ST_DMUL-1].nvx * $signed({1'b0, p[ST_DMUL-1].dt});
    nx[ST_DMUL].dpy = p[ST_DMUL-1].nvy * $signed({1'b0, p[ST_DMUL-1].dt});

    // position with saturation
    tpx = 46'(p[ST_POS-1].dpx) + 46'sd32768;
    tpy = 46'(p[ST_POS-1].dpy) + 46'sd32768;
    nx[ST_POS]     = p[ST_POS-1];
    nx[ST_POS].npx = sat_coord(31'(p[ST_POS-1].px) + 31'(tpx >>> 16));
    nx[ST_POS].npy = sat_coord(31'(p[ST_POS-1].py) + 31'(tpy >>> 16));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_ST; k++) begin
        p[k] <= nx[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_ST; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k < NUM_ST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  assign m_tvalid = vld[NUM_ST-1];
  assign m_tdata  = {7'd0, p[NUM_ST-1].alive, p[NUM_ST-1].life,
                     p[NUM_ST-1].npy, p[NUM_ST-1].npx};

  `ASSERT_CLK(a_alive_life, clk, rst, m_tvalid |-> (m_tdata[72] == (m_tdata[71:48] != 24'd0)), "alive disagrees with remaining life")
  `ASSERT_CLK(a_zero_len_seed, clk, rst, (vld[ST_SEL] && p[ST_SEL].root == 25'd0) |-> p[ST_SEL].use_seed, "zero distance not routed to seed")
  `ASSERT_CLK(a_unit_bound, clk, rst, (vld[ST_DIR-1] && !p[ST_DIR-1].use_seed) |-> (p[ST_DIR-1].qx <= UNIT_ONE && p[ST_DIR-1].qy <= UNIT_ONE), "radial component above one")

endmodule

`default_nettype wire
